### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// expr must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

### hw/rtl/nvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nvr_pkg;

  // default sizes
  localparam int ENTRIES_DEF    = 16;
  localparam int DIM_DEF        = 16;
  localparam int VALUE_BITS_DEF = 16;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int FIELD_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_KEY     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAIRS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET = 5'd16;

  // control tag that travels with each element through the distance pipe
  typedef struct packed {
    logic valid;
    logic first_d;   // first element of an entry
    logic last_d;    // last element of an entry
    logic last_e;    // last entry of the search
  } nvr_tag_t;

  // index width for n locations, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/nvr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface nvr_in_if import nvr_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic [FIELD_W-1:0]           entry;
  logic [FIELD_W-1:0]           element;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, command, entry, element, value, input ready);
  modport sink   (input valid, command, entry, element, value, output ready);
endinterface
`default_nettype wire

### hw/rtl/nvr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface nvr_out_if import nvr_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [FIELD_W-1:0]           best_entry;
  logic [FIELD_W-1:0]           out_element;
  logic signed [VALUE_BITS-1:0] out_value;
  logic                         last;

  modport source (output valid, best_entry, out_element, out_value, last, input ready);
  modport sink   (input valid, best_entry, out_element, out_value, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/nvr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module nvr_ram import nvr_pkg::*; #(
  parameter int WIDTH = VALUE_BITS_DEF,
  parameter int DEPTH = DIM_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [idx_w(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic                    re,
  input  wire logic [idx_w(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/nvr_dist_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module nvr_dist_unit import nvr_pkg::*; #(
  parameter int DIM        = DIM_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire nvr_tag_t                       tag_i,
  input  wire logic signed [VALUE_BITS-1:0]   key_i,
  input  wire logic signed [VALUE_BITS-1:0]   query_i,
  output      nvr_tag_t                       tag_o,
  output      logic [2*(VALUE_BITS+1)+idx_w(DIM)-1:0] sum_o
);
  localparam int DIFF_W = VALUE_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ACC_W  = SQ_W + idx_w(DIM);

  nvr_tag_t                 tag_d_r, tag_s_r, tag_a_r;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;

  // subtract, square, accumulate
  assign diff_nxt = $signed({key_i[VALUE_BITS-1], key_i})
                  - $signed({query_i[VALUE_BITS-1], query_i});
  assign sq_nxt   = SQ_W'(diff_r * diff_r);
  assign acc_nxt  = tag_s_r.first_d ? ACC_W'(sq_r) : acc_r + ACC_W'(sq_r);

  // tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_d_r <= '0;
      tag_s_r <= '0;
      tag_a_r <= '0;
    end else begin
      tag_d_r <= tag_i;
      tag_s_r <= tag_d_r;
      tag_a_r <= tag_s_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (tag_i.valid) begin
      diff_r <= diff_nxt;
    end
    if (tag_d_r.valid) begin
      sq_r <= sq_nxt;
    end
    if (tag_s_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign tag_o = tag_a_r;
  assign sum_o = acc_r;
endmodule
`default_nettype wire

### hw/rtl/nearest_vector_recall_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Write and non-final query transactions are each accepted while the sequencer idles.
// The final query element starts a search over pairs_in_use * dims_in_use key elements,
// one key element per cycle through the shared subtract/square unit.
// Each result then passes a payload memory read, then an output hold until it is taken.
// Reset: registers return to 16, sequencer idles; stores are not cleared.
module nearest_vector_recall_unit import nvr_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int DIM        = DIM_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  nvr_in_if.sink                     in_chan,
  nvr_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int EW    = idx_w(ENTRIES);
  localparam int DW    = idx_w(DIM);
  localparam int AW    = idx_w(ENTRIES * DIM);
  localparam int ACC_W = 2 * (VALUE_BITS + 1) + idx_w(DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_SHOW  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CFG_DATA_W-1:0] pairs_r, dims_r;
  logic [EW-1:0]         np_m1_c, np_m1_r;
  logic [DW-1:0]         nd_m1_c, nd_m1_r;
  logic                  accept, in_range, start, key_we, pay_we;
  logic                  issuing_r;
  logic [EW-1:0]         ii_r, ce_r, best_r;
  logic [DW-1:0]         id_r, od_r;
  nvr_tag_t              t1_r, done_tag;
  logic [ACC_W-1:0]      sum, best_sum_r;
  logic                  take_best, out_take, out_last;
  logic [AW-1:0]         waddr, key_raddr, pay_raddr;
  logic [VALUE_BITS-1:0] key_rdata, query_rdata, pay_rdata;

  // clamp configuration to the legal ranges
  always_comb begin
    if (pairs_r == '0) begin
      np_m1_c = '0;
    end else if (int'(pairs_r) > ENTRIES) begin
      np_m1_c = EW'(ENTRIES - 1);
    end else begin
      np_m1_c = EW'(pairs_r - 1'b1);
    end
    if (dims_r == '0) begin
      nd_m1_c = '0;
    end else if (int'(dims_r) > DIM) begin
      nd_m1_c = DW'(DIM - 1);
    end else begin
      nd_m1_c = DW'(dims_r - 1'b1);
    end
  end

  // input decode
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept   = in_chan.valid && in_chan.ready;
  assign in_range = int'(in_chan.element) < DIM;
  assign key_we   = accept && in_range && (in_chan.command == CMD_KEY)
                    && (int'(in_chan.entry) < ENTRIES);
  assign pay_we   = accept && in_range && (in_chan.command == CMD_PAYLOAD)
                    && (int'(in_chan.entry) < ENTRIES);
  assign start    = accept && in_range && (in_chan.command == CMD_QUERY)
                    && (int'(in_chan.element) == int'(nd_m1_c));
  assign waddr    = AW'(int'(in_chan.entry) * DIM + int'(in_chan.element));

  // memory addressing
  assign key_raddr = AW'(int'(ii_r) * DIM + int'(id_r));
  assign pay_raddr = AW'(int'(best_r) * DIM + int'(od_r));

  nvr_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES * DIM)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(in_chan.value),
    .re(issuing_r), .raddr(key_raddr), .rdata(key_rdata)
  );

  nvr_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES * DIM)) u_pay_ram (
    .clk(clk), .we(pay_we), .waddr(waddr), .wdata(in_chan.value),
    .re(state_r == ST_FETCH), .raddr(pay_raddr), .rdata(pay_rdata)
  );

  nvr_ram #(.WIDTH(VALUE_BITS), .DEPTH(DIM)) u_query_ram (
    .clk(clk),
    .we(accept && in_range && (in_chan.command == CMD_QUERY)),
    .waddr(DW'(in_chan.element)), .wdata(in_chan.value),
    .re(issuing_r), .raddr(id_r), .rdata(query_rdata)
  );

  nvr_dist_unit #(.DIM(DIM), .VALUE_BITS(VALUE_BITS)) u_dist (
    .clk(clk), .rst_n(rst_n), .tag_i(t1_r),
    .key_i(key_rdata), .query_i(query_rdata),
    .tag_o(done_tag), .sum_o(sum)
  );

  // running minimum, first entry wins ties
  assign take_best = done_tag.valid && done_tag.last_d
                     && ((ce_r == '0) || (sum < best_sum_r));
  assign out_last  = (od_r == nd_m1_r);
  assign out_take  = out_chan.valid && out_chan.ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done_tag.valid && done_tag.last_d && done_tag.last_e) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_SHOW;
      ST_SHOW: begin
        if (out_take) begin
          state_nxt = out_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pairs_r   <= CFG_RESET;
      dims_r    <= CFG_RESET;
      issuing_r <= 1'b0;
      t1_r      <= '0;
      ii_r      <= '0;
      id_r      <= '0;
      ce_r      <= '0;
      od_r      <= '0;
      best_r    <= '0;
      np_m1_r   <= '0;
      nd_m1_r   <= '0;
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_we && (cfg_index == REG_PAIRS)) begin
        pairs_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_DIMS)) begin
        dims_r <= cfg_data;
      end

      // search launch
      if (start) begin
        issuing_r <= 1'b1;
        ii_r      <= '0;
        id_r      <= '0;
        ce_r      <= '0;
        np_m1_r   <= np_m1_c;
        nd_m1_r   <= nd_m1_c;
      end

      // element issue, tag aligned with the memory read latency
      t1_r.valid   <= issuing_r;
      t1_r.first_d <= (id_r == '0);
      t1_r.last_d  <= (id_r == nd_m1_r);
      t1_r.last_e  <= (ii_r == np_m1_r);
      if (issuing_r) begin
        if (id_r == nd_m1_r) begin
          id_r <= '0;
          if (ii_r == np_m1_r) begin
            issuing_r <= 1'b0;
          end else begin
            ii_r <= ii_r + 1'b1;
          end
        end else begin
          id_r <= id_r + 1'b1;
        end
      end

      // completed entry sums
      if (done_tag.valid && done_tag.last_d) begin
        ce_r <= ce_r + 1'b1;
        if (take_best) begin
          best_r <= ce_r;
        end
        if (done_tag.last_e) begin
          od_r <= '0;
        end
      end

      // payload readout
      if ((state_r == ST_SHOW) && out_take && !out_last) begin
        od_r <= od_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_sum_r <= sum;
    end
  end

  // result channel
  assign out_chan.valid       = (state_r == ST_SHOW);
  assign out_chan.best_entry  = FIELD_W'(best_r);
  assign out_chan.out_element = FIELD_W'(od_r);
  assign out_chan.out_value   = pay_rdata;
  assign out_chan.last        = out_last;
endmodule
`default_nettype wire

### hw/rtl/nvr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nvr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // one transaction in flight: no new input while results are offered
  `ASSERT_NEVER(a_busy_excl, clk, rst_n, in_ready && out_valid)
  // the run ends with the last result
  `ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_ready && out_last, !out_valid)
  // more results follow a non-final one, input stays closed
  `ASSERT_NEXT(a_run_busy, clk, rst_n, out_valid && out_ready && !out_last, !in_ready)
endmodule

bind nearest_vector_recall_unit nvr_checker u_nvr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_last (out_chan.last)
);
`default_nettype wire
